>>> design/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants of the ADSR envelope block
// Register indexes, phase codes and the fixed field widths.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int TICKS_W  = 24;  // attack, decay and release lengths
  localparam int LVL_W    = 16;  // levels, unsigned fixed point
  localparam int LEVEL_FRAC_BITS = 15;  // level fraction bits, Q1.15
  localparam int PH_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W   = TICKS_W + LVL_W;  // ticks times level

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd4;

  localparam logic [TICKS_W-1:0] ATTACK_RST  = 24'd4410;
  localparam logic [TICKS_W-1:0] DECAY_RST   = 24'd4410;
  localparam logic [TICKS_W-1:0] RELEASE_RST = 24'd8820;
  localparam logic [LVL_W-1:0]   START_RST   = 16'd32768;
  localparam logic [LVL_W-1:0]   SUSTAIN_RST = 16'd32768;

  typedef enum logic [PH_W-1:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_SILENT  = 3'd4
  } phase_e;

endpackage

>>> design/adsr_div.sv
// ----------------------------------------------------------------------------
// adsr_div: pipelined restoring divider
// One quotient bit per stage, MSB first; sideband travels with each item.
// Caller guarantees num < den * 2**Q_W.
// ----------------------------------------------------------------------------
module adsr_div #(
  parameter int NUM_W  = 40,
  parameter int DEN_W  = 24,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W-1:0]  rem_q  [Q_W-1];
  logic [Q_W-1:0]    quo_q  [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];
  logic              vld_q  [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int Bit = Q_W - 1 - j;
    logic [NUM_W-1:0]  rem_in;
    logic [NUM_W-1:0]  dsh;
    logic [Q_W-1:0]    quo_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;
    logic              take;

    if (j == 0) begin : g_first
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    assign dsh  = NUM_W'(den_in) << Bit;
    assign take = (rem_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j]  <= take ? (quo_in | (Q_W'(1) << Bit)) : quo_in;
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end

    // the last stage needs no remainder
    if (j < Q_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= take ? (rem_in - dsh) : rem_in;
        end
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

>>> design/adsr_envelope_amplitude_top.sv
// ----------------------------------------------------------------------------
// adsr_envelope_amplitude_top: linear ADSR envelope amplitude
// Gives the envelope level of one note from current, on and off ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries now, on and off ticks of a
//   note; a note is held while on_tick > off_tick. Each input transfer yields
//   exactly one output transfer (out_valid_o/out_ready_i) with level (unsigned,
//   LEVEL_FRAC_BITS fraction bits), phase and silent flag, in order.
//   Throughput is one item per cycle while the receiver does not stall: two
//   pipelined dividers of 16 stages each (one quotient bit per stage) make up
//   most of the depth, and every stage holds one item.
//   The whole pipeline advances together; when the receiver stalls with a
//   result pending, every stage holds and in_ready_o drops, so nothing is
//   lost or repeated. Bubbles ride along as cleared valid bits.
//   Reset empties the pipeline and loads the default register values
//   (attack 4410, decay 4410, release 8820, start and sustain 1.0).
//   Write cfg_* only while the pipeline is empty; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module adsr_envelope_amplitude_top #(
  parameter int TIME_WIDTH      = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [adsr_pkg::TICKS_W-1:0]     cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [TIME_WIDTH-1:0]            now_tick_i,
  input  logic [TIME_WIDTH-1:0]            on_tick_i,
  input  logic [TIME_WIDTH-1:0]            off_tick_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [adsr_pkg::LVL_W-1:0]       level_o,
  output logic [adsr_pkg::PH_W-1:0]        phase_o,
  output logic                             silent_o
);

  localparam int TW = TIME_WIDTH;
  localparam int TK = adsr_pkg::TICKS_W;
  localparam int LW = adsr_pkg::LVL_W;
  localparam int PW = adsr_pkg::PROD_W;
  // compare width wide enough for a time difference and for attack + decay
  localparam int CW = (TW + 1 > TK + 2) ? TW + 1 : TK + 2;
  localparam logic [31:0] LevelOne = 32'(64'd1 << adsr_pkg::LEVEL_FRAC_BITS);
  localparam logic [31:0] QuietLvl =
    32'(((64'd1 << adsr_pkg::LEVEL_FRAC_BITS) + 64'd50) / 64'd100);
  // sideband widths through the two dividers
  localparam int S1W = 1 + 1 + adsr_pkg::PH_W + 1 + LW + 1 + 1 + TK;
  localparam int S2W = 1 + 1 + adsr_pkg::PH_W + 1 + LW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TK-1:0] attack_q, decay_q, release_q;
  logic [LW-1:0] start_q, sustain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= adsr_pkg::ATTACK_RST;
      decay_q   <= adsr_pkg::DECAY_RST;
      release_q <= adsr_pkg::RELEASE_RST;
      start_q   <= adsr_pkg::START_RST;
      sustain_q <= adsr_pkg::SUSTAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adsr_pkg::CFG_ATTACK:  attack_q  <= cfg_data_i;
        adsr_pkg::CFG_DECAY:   decay_q   <= cfg_data_i;
        adsr_pkg::CFG_RELEASE: release_q <= cfg_data_i;
        adsr_pkg::CFG_START:   start_q   <= cfg_data_i[LW-1:0];
        adsr_pkg::CFG_SUSTAIN: sustain_q <= cfg_data_i[LW-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances together unless a result is stuck at the output
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // --------------------------------------------------------------------------
  // Stage 1: time differences
  // --------------------------------------------------------------------------
  logic          s1_vld_q, s1_held_q;
  logic [TW:0]   s1_life_q, s1_t_q;
  logic          held_d;

  assign held_d = (on_tick_i > off_tick_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_held_q <= held_d;
      // held: elapsed since on; released: level frozen at off, so off - on
      s1_life_q <= {1'b0, (held_d ? now_tick_i : off_tick_i)} - {1'b0, on_tick_i};
      s1_t_q    <= {1'b0, now_tick_i} - {1'b0, off_tick_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pick segment, set up multiply and divide operands
  // --------------------------------------------------------------------------
  logic [CW-1:0] life_u, a_u, ad_u, t_u;
  logic          seg_att, seg_dec;
  logic [LW:0]   diff;
  logic          dsgn_d;
  logic [LW-1:0] mag_d;

  assign life_u  = CW'(s1_life_q);
  assign a_u     = CW'(attack_q);
  assign ad_u    = CW'(attack_q) + CW'(decay_q);
  assign t_u     = CW'(s1_t_q);
  assign seg_att = (life_u <= a_u);
  assign seg_dec = (life_u <= ad_u);
  assign diff    = {1'b0, sustain_q} - {1'b0, start_q};
  assign dsgn_d  = diff[LW];
  assign mag_d   = dsgn_d ? LW'(-diff) : diff[LW-1:0];

  logic          s2_vld_q, s2_held_q, s2_neg_q, s2_direct_q, s2_dsgn_q, s2_tneg_q;
  logic [adsr_pkg::PH_W-1:0] s2_ph_q;
  logic [LW-1:0] s2_dval_q, s2_coef_q;
  logic [TK-1:0] s2_x_q, s2_den_q, s2_tc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_held_q <= s1_held_q;
      s2_neg_q  <= s1_held_q && s1_life_q[TW];
      s2_tneg_q <= s1_t_q[TW];
      // hold the release time at its end
      s2_tc_q   <= (t_u > CW'(release_q)) ? release_q : TK'(t_u);
      s2_dsgn_q <= dsgn_d;
      if (seg_att) begin
        s2_ph_q     <= adsr_pkg::PH_ATTACK;
        s2_direct_q <= (attack_q == '0);
        s2_dval_q   <= start_q;
        s2_x_q      <= TK'(life_u);
        s2_coef_q   <= start_q;
        s2_den_q    <= attack_q;
      end else if (seg_dec) begin
        s2_ph_q     <= adsr_pkg::PH_DECAY;
        s2_direct_q <= 1'b0;
        s2_dval_q   <= start_q;
        s2_x_q      <= TK'(life_u - a_u);
        s2_coef_q   <= mag_d;
        s2_den_q    <= decay_q;
      end else begin
        s2_ph_q     <= adsr_pkg::PH_SUSTAIN;
        s2_direct_q <= 1'b1;
        s2_dval_q   <= sustain_q;
        s2_x_q      <= TK'(life_u);
        s2_coef_q   <= mag_d;
        s2_den_q    <= decay_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: elapsed times slope
  // --------------------------------------------------------------------------
  logic          s3_vld_q;
  logic [PW-1:0] s3_prod_q;
  logic [TK-1:0] s3_den_q;
  logic [S1W-1:0] s3_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_prod_q <= PW'(s2_x_q) * PW'(s2_coef_q);
      s3_den_q  <= s2_den_q;
      s3_side_q <= {s2_held_q, s2_neg_q, s2_ph_q, s2_direct_q, s2_dval_q,
                    s2_dsgn_q, s2_tneg_q, s2_tc_q};
    end
  end

  // --------------------------------------------------------------------------
  // Divider 1: held level quotient
  // --------------------------------------------------------------------------
  logic           d1_vld;
  logic [LW-1:0]  d1_quo;
  logic [S1W-1:0] d1_side;

  adsr_div #(
    .NUM_W (PW),
    .DEN_W (TK),
    .Q_W   (LW),
    .SIDE_W(S1W)
  ) u_div_held (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s3_vld_q),
    .num_i  (s3_prod_q),
    .den_i  (s3_den_q),
    .side_i (s3_side_q),
    .valid_o(d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side)
  );

  logic          d1_held, d1_neg, d1_direct, d1_dsgn, d1_tneg;
  logic [adsr_pkg::PH_W-1:0] d1_ph;
  logic [LW-1:0] d1_dval;
  logic [TK-1:0] d1_tc;

  assign {d1_held, d1_neg, d1_ph, d1_direct, d1_dval, d1_dsgn, d1_tneg, d1_tc} = d1_side;

  // --------------------------------------------------------------------------
  // Stage 4: held level
  // --------------------------------------------------------------------------
  logic          s4_vld_q, s4_held_q, s4_neg_q, s4_tneg_q;
  logic [adsr_pkg::PH_W-1:0] s4_ph_q;
  logic [LW-1:0] s4_hl_q, hl_d;
  logic [TK-1:0] s4_tc_q;

  always_comb begin
    if (d1_direct) begin
      hl_d = d1_dval;
    end else if (d1_ph == adsr_pkg::PH_ATTACK) begin
      hl_d = d1_quo;
    end else if (d1_dsgn) begin
      hl_d = start_q - d1_quo;
    end else begin
      hl_d = start_q + d1_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_held_q <= d1_held;
      s4_neg_q  <= d1_neg;
      s4_tneg_q <= d1_tneg;
      s4_ph_q   <= d1_ph;
      s4_hl_q   <= hl_d;
      s4_tc_q   <= d1_tc;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: release drop product
  // --------------------------------------------------------------------------
  logic           s5_vld_q;
  logic [PW-1:0]  s5_prod_q;
  logic [S2W-1:0] s5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_prod_q <= PW'(s4_tc_q) * PW'(s4_hl_q);
      s5_side_q <= {s4_held_q, s4_neg_q, s4_ph_q, s4_tneg_q, s4_hl_q};
    end
  end

  // --------------------------------------------------------------------------
  // Divider 2: release drop quotient
  // --------------------------------------------------------------------------
  logic           d2_vld;
  logic [LW-1:0]  d2_quo;
  logic [S2W-1:0] d2_side;

  adsr_div #(
    .NUM_W (PW),
    .DEN_W (TK),
    .Q_W   (LW),
    .SIDE_W(S2W)
  ) u_div_rel (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s5_vld_q),
    .num_i  (s5_prod_q),
    .den_i  (release_q),
    .side_i (s5_side_q),
    .valid_o(d2_vld),
    .quo_o  (d2_quo),
    .side_o (d2_side)
  );

  logic          d2_held, d2_neg, d2_tneg;
  logic [adsr_pkg::PH_W-1:0] d2_ph;
  logic [LW-1:0] d2_hl;

  assign {d2_held, d2_neg, d2_ph, d2_tneg, d2_hl} = d2_side;

  // --------------------------------------------------------------------------
  // Output stage: select, quiet threshold, saturate
  // --------------------------------------------------------------------------
  logic [LW-1:0] lvl_raw, lvl_d;
  logic [adsr_pkg::PH_W-1:0] ph_raw, ph_d;

  always_comb begin
    if (d2_held) begin
      lvl_raw = d2_neg ? '0 : d2_hl;
      ph_raw  = d2_ph;
    end else begin
      lvl_raw = (d2_tneg || release_q == '0) ? '0 : d2_hl - d2_quo;
      ph_raw  = adsr_pkg::PH_RELEASE;
    end
    lvl_d = lvl_raw;
    ph_d  = ph_raw;
    // drop anything at or below the quiet level
    if (32'(lvl_raw) <= QuietLvl) begin
      lvl_d = '0;
      ph_d  = adsr_pkg::PH_SILENT;
    end else if (32'(lvl_raw) > LevelOne) begin
      lvl_d = LW'(LevelOne);
    end
  end

  logic          out_vld_q;
  logic [LW-1:0] level_q;
  logic [adsr_pkg::PH_W-1:0] phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      level_q <= lvl_d;
      phase_q <= ph_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign level_o     = level_q;
  assign phase_o     = phase_q;
  assign silent_o    = (level_q == '0);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_silent_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (silent_o == (phase_o == adsr_pkg::PH_SILENT)))
    else $error("silent flag and silenced phase disagree");

  a_quiet_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !silent_o) |-> (32'(level_o) > QuietLvl))
    else $error("nonzero level at or below quiet threshold");

  a_level_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(level_o) <= LevelOne))
    else $error("level above full scale");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(level_o) && !$past(in_ready_o)))
    else $error("stall did not freeze the pipeline");

endmodule

>>> tb/adsr_envelope_amplitude_top_test.sv
// ----------------------------------------------------------------------------
// adsr_envelope_amplitude_top_test: self-checking test of the ADSR envelope
// Drives note ticks through the valid/ready input, predicts level, phase and
// silent flag for each transfer, and checks every output transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adsr_envelope_amplitude_top_test;

  localparam int TW       = 32;
  localparam int TKW      = adsr_pkg::TICKS_W;
  localparam int LATENCY  = 38;
  localparam int NUM_RAND = 648;

  typedef struct packed {
    logic [adsr_pkg::LVL_W-1:0] level;
    adsr_pkg::phase_e           phase;
    logic                       silent;
  } envelope_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [adsr_pkg::TICKS_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [TW-1:0] now_tick_i, on_tick_i, off_tick_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [adsr_pkg::LVL_W-1:0] level_o;
  logic [adsr_pkg::PH_W-1:0] phase_o;
  logic silent_o;

  // Predictor copy of the register file
  longint m_attack, m_decay, m_release, m_start, m_sustain;

  envelope_t expected_envelopes[$];
  int  fail_count;
  bit  hold_off_req;   // ask the receiver for a long stall
  bit  quiet_rx;       // receiver takes every transfer at once

  adsr_envelope_amplitude_top DUT (.*);

  // 20 ns clock
  always begin
    clk_i = 1'b0; #10;
    clk_i = 1'b1; #10;
  end

  // Level of a held note at elapsed time life >= 0
  function automatic longint held_level(longint life, output adsr_pkg::phase_e ph);
    if (life <= m_attack) begin
      ph = adsr_pkg::PH_ATTACK;
      if (m_attack == 0) return m_start;
      return (life * m_start) / m_attack;
    end
    if (life <= m_attack + m_decay) begin
      ph = adsr_pkg::PH_DECAY;
      return m_start + ((life - m_attack) * (m_sustain - m_start)) / m_decay;
    end
    ph = adsr_pkg::PH_SUSTAIN;
    return m_sustain;
  endfunction

  function automatic envelope_t predict_envelope(logic [TW-1:0] now_t,
                                                 logic [TW-1:0] on_t,
                                                 logic [TW-1:0] off_t);
    longint  now_l, on_l, off_l, lvl, rel, t;
    adsr_pkg::phase_e  ph, unused;
    envelope_t e;
    now_l = now_t; on_l = on_t; off_l = off_t;
    lvl = 0;
    ph  = adsr_pkg::PH_SILENT;
    if (on_l > off_l) begin
      if (now_l - on_l >= 0) lvl = held_level(now_l - on_l, ph);
    end else begin
      rel = held_level(off_l - on_l, unused);
      t   = now_l - off_l;
      ph  = adsr_pkg::PH_RELEASE;
      if (t < 0 || m_release == 0) lvl = 0;
      else begin
        if (t > m_release) t = m_release;
        lvl = rel - (t * rel) / m_release;
      end
    end
    // Drop anything at or below 0.01 of full scale
    if (lvl <= 328) begin
      lvl = 0;
      ph  = adsr_pkg::PH_SILENT;
    end
    if (lvl > 32768) lvl = 32768;
    e.level  = lvl[adsr_pkg::LVL_W-1:0];
    e.phase  = ph;
    e.silent = (lvl == 0);
    return e;
  endfunction

  // Random gap: mostly short, occasionally long
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic write_reg(logic [adsr_pkg::CFG_IDX_W-1:0] idx,
                           logic [adsr_pkg::TICKS_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      adsr_pkg::CFG_ATTACK:  m_attack  = val;
      adsr_pkg::CFG_DECAY:   m_decay   = val;
      adsr_pkg::CFG_RELEASE: m_release = val;
      adsr_pkg::CFG_START:   m_start   = val[adsr_pkg::LVL_W-1:0];
      adsr_pkg::CFG_SUSTAIN: m_sustain = val[adsr_pkg::LVL_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_envelope(int a, int d, int r, int s0, int s1);
    write_reg(adsr_pkg::CFG_ATTACK, TKW'(a));
    write_reg(adsr_pkg::CFG_DECAY, TKW'(d));
    write_reg(adsr_pkg::CFG_RELEASE, TKW'(r));
    write_reg(adsr_pkg::CFG_START, TKW'(s0));
    write_reg(adsr_pkg::CFG_SUSTAIN, TKW'(s1));
  endtask

  // Send one note query; hold valid and payload until the transfer
  task automatic send_note(logic [TW-1:0] now_t, logic [TW-1:0] on_t,
                           logic [TW-1:0] off_t, bit gaps);
    int gap;
    gap = gaps ? rand_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_tick_i <= now_t;
    on_tick_i  <= on_t;
    off_tick_i <= off_t;
    do @(posedge clk_i); while (!in_ready_o);
    expected_envelopes.insert(expected_envelopes.size(),
                              predict_envelope(now_t, on_t, off_t));
  endtask

  // Wait until every expected result is in, then let the pipeline drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_envelopes.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // Random note near the interesting boundaries of the current envelope
  task automatic send_random_note(bit gaps);
    logic [TW-1:0] on_t, off_t, now_t;
    longint span;
    int sel;
    span = m_attack + m_decay + m_release + 16;
    sel  = $urandom_range(0, 9);
    if (sel == 0) begin
      now_t = $urandom; on_t = $urandom; off_t = $urandom;
    end else begin
      on_t = $urandom;
      if (sel < 5) begin
        // held note
        off_t = on_t - $urandom_range(0, 1000);
        if (off_t >= on_t) off_t = 0;
        now_t = on_t + $urandom_range(0, 32'(span)) - 4;
      end else begin
        // released note
        if (on_t > 32'hF000_0000) on_t = on_t - 32'h1000_0000;
        off_t = on_t + $urandom_range(0, 32'(span));
        now_t = off_t + $urandom_range(0, 32'(m_release + 20)) - 4;
      end
      if (on_t == 0 && sel < 5) on_t = 1;
    end
    send_note(now_t, on_t, off_t, gaps);
  endtask

  // Extreme field values and special cases, first at reset settings, then at changed settings
  task automatic test_directed();
    send_note(32'd100, 32'd0, 32'd0, 1'b0);          // released at once, no ramp
    send_note(32'd2205, 32'd1, 32'd0, 1'b0);          // mid attack
    send_note(32'd4411, 32'd1, 32'd0, 1'b0);          // end of attack
    send_note(32'd6616, 32'd1, 32'd0, 1'b0);          // decay
    send_note(32'd9000, 32'd1, 32'd0, 1'b0);          // sustain
    send_note(32'd0, 32'd10, 32'd0, 1'b0);            // negative elapsed, held
    send_note(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_note(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
    send_note(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_note(32'd20000, 32'd0, 32'd10000, 1'b0);     // past the release end
    send_note(32'd5000, 32'd0, 32'd10000, 1'b0);      // negative elapsed, released
    send_note(32'd40000, 32'd0, 32'd10000, 1'b0);     // past the release
    send_note(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_note(32'd18815, 32'd0, 32'd10000, 1'b0);     // near the quiet threshold
    drain();
    // Zero attack and zero release
    set_envelope(0, 100, 0, 32768, 16384);
    send_note(32'd5, 32'd5, 32'd0, 1'b0);
    send_note(32'd50, 32'd5, 32'd0, 1'b0);
    send_note(32'd500, 32'd0, 32'd200, 1'b0);
    drain();
    // Levels above 1.0 saturate; widest lengths
    set_envelope(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_note(32'hFF_FFFF, 32'd0, 32'd0, 1'b0);
    send_note(32'h0FF_FFFF, 32'd1, 32'd0, 1'b0);
    send_note(32'h2FF_FFFF, 32'd1, 32'd0, 1'b0);
    send_note(32'h1FF_FFFF, 32'd0, 32'h0FF_FFFF, 1'b0);
    drain();
    // Unknown register index is dropped
    write_reg(3'd7, 24'h00_1234);
    write_reg(3'd5, 24'h00_0001);
    send_note(32'd8000, 32'd1, 32'd0, 1'b0);
    drain();
  endtask

  task automatic test_random_settings();
    int n;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_envelope(4410, 4410, 8820, 32768, 32768);
        1: set_envelope(0, 0, 0, 0, 0);
        2: set_envelope(1, 1, 1, 32768, 0);
        default: set_envelope($urandom_range(0, 3000), $urandom_range(0, 3000),
                              $urandom_range(0, 6000), $urandom_range(0, 40000),
                              $urandom_range(0, 40000));
      endcase
      quiet_rx = (p == 2);
      n = NUM_RAND / 6;
      for (int i = 0; i < n; i++) send_random_note(!quiet_rx);
      drain();
    end
    quiet_rx = 1'b0;
  endtask

  // Receiver stalls long while the sender keeps offering back to back
  task automatic test_backpressure();
    set_envelope($urandom_range(100, 2000), $urandom_range(0, 2000),
                 $urandom_range(1, 4000), 32768, $urandom_range(0, 32768));
    hold_off_req = 1'b1;
    for (int i = 0; i < 80; i++) send_random_note(1'b0);
    drain();
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      gap = quiet_rx ? 0 : rand_gap();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Check each output transfer against the oldest prediction
  always @(posedge clk_i) begin
    envelope_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_envelopes.size() == 0) begin
        $display("%0t: unexpected result level=%0d phase=%0d silent=%0d",
                 $time, level_o, phase_o, silent_o);
        fail_count++;
      end else begin
        e = expected_envelopes.pop_front();
        if (level_o !== e.level) begin
          $display("%0t: level expected %0d actual %0d", $time, e.level, level_o);
          fail_count++;
        end
        if (phase_o !== e.phase) begin
          $display("%0t: phase expected %0d actual %0d", $time, e.phase, phase_o);
          fail_count++;
        end
        if (silent_o !== e.silent) begin
          $display("%0t: silent expected %0d actual %0d", $time, e.silent, silent_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    fail_count   = 0;
    hold_off_req = 1'b0;
    quiet_rx     = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = adsr_pkg::CFG_ATTACK;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    now_tick_i   = '0;
    on_tick_i    = '0;
    off_tick_i   = '0;
    m_attack  = adsr_pkg::ATTACK_RST;
    m_decay   = adsr_pkg::DECAY_RST;
    m_release = adsr_pkg::RELEASE_RST;
    m_start   = adsr_pkg::START_RST;
    m_sustain = adsr_pkg::SUSTAIN_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_settings();
    if (fail_count == 0 && expected_envelopes.size() == 0)
      $display("adsr_envelope_amplitude_top_test passed");
    else
      $display("adsr_envelope_amplitude_top_test failed");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5ms;
    $display("adsr_envelope_amplitude_top_test failed");
    $finish;
  end

endmodule
